FILE: rtl/core/itfmt_pkg.sv
// Shared types, constants and helpers for the integer to ASCII formatter.
// No dependencies; used by every module under rtl/core.

package itfmt_pkg;

   // Width of the numeric value handled by the block
   localparam int unsigned VALUE_W   = 32;
   // Digit store depth: room for the ten decimal digits of a 32-bit magnitude
   localparam int unsigned DIG_DEPTH = 11;
   localparam int unsigned DIG_IDX_W = $clog2(DIG_DEPTH);
   localparam int unsigned CHAR_W    = 7;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned RSP_DATA_W = 16;

   // ceil(2^35 / 10): q = (v * RECIP_DEC) >> 35 is exact for every 32-bit v
   localparam logic [VALUE_W-1:0] RECIP_DEC = 32'hCCCC_CCCD;
   localparam int unsigned        RECIP_SHIFT = 35;

   // Command codes
   localparam logic [1:0] CMD_DEC       = 2'd0;
   localparam logic [1:0] CMD_HEX_LOWER = 2'd1;
   localparam logic [1:0] CMD_HEX_UPPER = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS  = 7'd45;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'd97;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;

   // Result of one pass through the shared digit unit
   typedef struct packed {
      logic [VALUE_W-1:0] quotient;
      logic [3:0]         digit;
   } split_type;

   // One character handed to the output register
   typedef struct packed {
      logic               is_sign;
      logic [3:0]         digit;
      logic               upper;
      logic               last;
      logic [COUNT_W-1:0] count;
   } char_req_type;

   // Map a digit value (0..15) to its ASCII code
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] digit,
                                                        input logic       upper);
      logic [CHAR_W-1:0] code;
      begin
         if (digit < 4'd10) begin
            code = ASCII_ZERO + CHAR_W'(digit);
         end else if (upper) begin
            code = ASCII_UPPER_A + CHAR_W'(digit - 4'd10);
         end else begin
            code = ASCII_LOWER_A + CHAR_W'(digit - 4'd10);
         end
         return code;
      end
   endfunction

endpackage

FILE: rtl/core/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: sequencer, digit store and
// glue. Depends on itfmt_pkg, itfmt_divider and itfmt_out_reg.
//
// Usage:
//   req channel: req_tdata carries the 32-bit value, req_tuser the command
//   (0 signed decimal, 1 hex lower case, 2 or 3 hex upper case). A request
//   is taken when req_tvalid and req_tready are high at a rising edge.
//   rsp channel: one beat per character, most significant first, with the
//   minus sign ahead of a negative decimal. rsp_tlast marks the final
//   character; rsp_tdata holds the ASCII code and the running count.
//   Timing: one request is worked on at a time. The digit unit forms each
//   decimal digit by a registered reciprocal multiply and then a split, and
//   each hex digit by a split alone; characters then leave one per cycle
//   from the output register while rsp_tready is high. req_tready returns
//   high once the last character is loaded into the output register.
//   Stall: while rsp_tready is low the current character holds and the
//   sequencer waits. Reset clears the sequencer and the output valid; no
//   memory needs clearing.

module integer_to_ascii_formatter (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [itfmt_pkg::VALUE_W-1:0]       req_tdata,  // [31:0] value
   input  logic [1:0]                          req_tuser,  // [1:0] cmd
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [itfmt_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [6:0] char_code,
                                                           // [10:7] char_count
   output logic                                rsp_tlast   // last_char
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MUL   = 4'b0010,
      ST_SPLIT = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [itfmt_pkg::VALUE_W-1:0]      work_ff, work_in;
   logic                               hex_ff, hex_in;
   logic                               upper_ff, upper_in;
   logic                               sign_ff, sign_in;
   logic [itfmt_pkg::COUNT_W-1:0]      dig_cnt_ff, dig_cnt_in;
   logic [itfmt_pkg::COUNT_W-1:0]      pos_ff, pos_in;
   logic [3:0]                         dig_buf_ff [itfmt_pkg::DIG_DEPTH];
   logic                               dig_we;
   logic [itfmt_pkg::DIG_IDX_W-1:0]    wr_idx;
   logic [itfmt_pkg::DIG_IDX_W-1:0]    rd_idx;
   logic                               req_fire;
   logic                               req_neg;
   logic                               out_free;
   logic                               out_load;
   itfmt_pkg::split_type               split;
   itfmt_pkg::char_req_type            char_req;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_neg    = (req_tuser == itfmt_pkg::CMD_DEC) &&
                       req_tdata[itfmt_pkg::VALUE_W-1];

   assign wr_idx = dig_cnt_ff[itfmt_pkg::DIG_IDX_W-1:0];
   assign rd_idx = itfmt_pkg::DIG_IDX_W'(dig_cnt_ff - 4'd1);

   itfmt_divider u_divider (
      .clock    (clock),
      .dividend (work_ff),
      .hex_mode (hex_ff),
      .split    (split)
   );

   // Build the next character: sign first, then stored digits top down
   always_comb begin
      char_req.is_sign = sign_ff;
      char_req.digit   = dig_buf_ff[rd_idx];
      char_req.upper   = upper_ff;
      char_req.last    = !sign_ff && (dig_cnt_ff == 4'd1);
      char_req.count   = pos_ff + 4'd1;
   end

   assign out_load = (state_ff == ST_EMIT) && out_free;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      work_in    = work_ff;
      hex_in     = hex_ff;
      upper_in   = upper_ff;
      sign_in    = sign_ff;
      dig_cnt_in = dig_cnt_ff;
      pos_in     = pos_ff;
      dig_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               hex_in     = (req_tuser != itfmt_pkg::CMD_DEC);
               upper_in   = req_tuser[1];
               sign_in    = req_neg;
               work_in    = req_neg ? (~req_tdata + 1'b1) : req_tdata;
               dig_cnt_in = '0;
               pos_in     = '0;
               state_in   = (req_tuser == itfmt_pkg::CMD_DEC) ? ST_MUL : ST_SPLIT;
            end
         end
         ST_MUL: begin
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            // Store the low digit and advance to the quotient
            dig_we     = 1'b1;
            dig_cnt_in = dig_cnt_ff + 4'd1;
            work_in    = split.quotient;
            if (split.quotient == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = hex_ff ? ST_SPLIT : ST_MUL;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               pos_in = pos_ff + 4'd1;
               if (sign_ff) begin
                  sign_in = 1'b0;
               end else begin
                  dig_cnt_in = dig_cnt_ff - 4'd1;
                  if (dig_cnt_ff == 4'd1) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      hex_ff     <= hex_in;
      upper_ff   <= upper_in;
      sign_ff    <= sign_in;
      dig_cnt_ff <= dig_cnt_in;
      pos_ff     <= pos_in;
   end

   // Digit store, filled least significant first
   always_ff @(posedge clock) begin
      if (dig_we) begin
         dig_buf_ff[wr_idx] <= split.digit;
      end
   end

   itfmt_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .char_req   (char_req),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/core/itfmt_divider.sv
// Shared digit unit: splits the working value into quotient and low digit,
// by ten through a registered reciprocal multiply, or by sixteen by shift.
// Depends on itfmt_pkg.

module itfmt_divider (
   input  logic                          clock,
   input  logic [itfmt_pkg::VALUE_W-1:0] dividend,
   input  logic                          hex_mode,
   output itfmt_pkg::split_type          split
);

   logic [2*itfmt_pkg::VALUE_W-1:0] prod_ff;
   logic [2*itfmt_pkg::VALUE_W-1:0] prod_in;
   logic [itfmt_pkg::VALUE_W-1:0]   q_dec;
   logic [itfmt_pkg::VALUE_W-1:0]   rem_dec;

   // Register the reciprocal product; the dividend holds for the next cycle
   assign prod_in = (2*itfmt_pkg::VALUE_W)'(dividend) *
                    (2*itfmt_pkg::VALUE_W)'(itfmt_pkg::RECIP_DEC);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Quotient by ten from the product, remainder by shift-and-subtract
   assign q_dec   = itfmt_pkg::VALUE_W'(prod_ff >> itfmt_pkg::RECIP_SHIFT);
   assign rem_dec = dividend - (q_dec << 3) - (q_dec << 1);

   // Select the radix
   always_comb begin
      if (hex_mode) begin
         split.quotient = dividend >> 4;
         split.digit    = dividend[3:0];
      end else begin
         split.quotient = q_dec;
         split.digit    = rem_dec[3:0];
      end
   end

endmodule

FILE: rtl/core/itfmt_out_reg.sv
// Output register of the formatter: turns one digit or sign into ASCII and
// holds it on the response channel until taken. Depends on itfmt_pkg.

module itfmt_out_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  itfmt_pkg::char_req_type             char_req,
   output logic                                free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [itfmt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast
);

   logic                               valid_ff;
   logic                               valid_in;
   logic [itfmt_pkg::CHAR_W-1:0]       code_ff;
   logic [itfmt_pkg::CHAR_W-1:0]       code_in;
   logic [itfmt_pkg::COUNT_W-1:0]      count_ff;
   logic                               last_ff;

   // Room for a new character when empty or being taken this cycle
   assign free = !valid_ff || rsp_tready;

   assign code_in = char_req.is_sign ? itfmt_pkg::ASCII_MINUS
                  : itfmt_pkg::digit_to_ascii(char_req.digit, char_req.upper);

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload
   always_ff @(posedge clock) begin
      if (load) begin
         code_ff  <= code_in;
         count_ff <= char_req.count;
         last_ff  <= char_req.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{(itfmt_pkg::RSP_DATA_W - itfmt_pkg::COUNT_W - itfmt_pkg::CHAR_W){1'b0}},
                        count_ff, code_ff};

endmodule
